// File: rtl/core/lidar_scan_segmenter_assert.svh
// Assertion macros used by the segmenter top level.
// Each macro expects clk and rst_n in scope.
`ifndef LIDAR_SCAN_SEGMENTER_ASSERT_SVH
`define LIDAR_SCAN_SEGMENTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lidar_scan_segmenter: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lidar_scan_segmenter: next-cycle check failed");

`endif

// File: rtl/core/lss_pkg.sv
package lss_pkg;

  localparam int AZ_W       = 16;
  localparam int CUT_W      = 17;
  localparam int THR_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [AZ_W-1:0]  FULL_TURN = AZ_W'(36000);
  localparam logic [AZ_W-1:0]  HALF_TURN = AZ_W'(18000);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(200000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_START        = 2'd0,
    CFG_DURATION_THRESHOLD = 2'd1,
    CFG_STAMP_FROM_FIRST   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic scan_done;
    logic deferred;
    logic starts_scan;
  } lss_flags_t;

  // Fold a raw 16-bit angle into one turn; the input is below two turns.
  function automatic logic [AZ_W-1:0] lss_reduce_az(input logic [AZ_W-1:0] a);
    lss_reduce_az = (a >= FULL_TURN) ? a - FULL_TURN : a;
  endfunction

  // (a - s) mod one turn, both operands already inside one turn.
  function automatic logic [AZ_W-1:0] lss_wrap_diff(input logic [AZ_W-1:0] a,
                                                   input logic [AZ_W-1:0] s);
    logic [AZ_W:0] d;
    d = {1'b0, a} - {1'b0, s};
    lss_wrap_diff = d[AZ_W] ? d[AZ_W-1:0] + FULL_TURN : d[AZ_W-1:0];
  endfunction

endpackage

// File: rtl/core/lss_pkt_if.sv
interface lss_pkt_if import lss_pkg::*; #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [AZ_W-1:0]      azimuth;
  logic [TIME_BITS-1:0] stamp;

  modport source (output valid, azimuth, stamp, input ready);
  modport sink   (input valid, azimuth, stamp, output ready);
endinterface

// File: rtl/core/lss_res_if.sv
interface lss_res_if import lss_pkg::*; #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic                 scan_done;
  logic                 deferred;
  logic                 starts_scan;
  logic [TIME_BITS-1:0] scan_stamp;
  logic [AZ_W-1:0]      coverage_now;

  modport source (output valid, scan_done, deferred, starts_scan, scan_stamp, coverage_now,
                  input ready);
  modport sink   (input valid, scan_done, deferred, starts_scan, scan_stamp, coverage_now,
                  output ready);
endinterface

// File: rtl/core/lss_in_reg.sv
module lss_in_reg import lss_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [AZ_W-1:0]      req_azimuth,
  input  logic [TIME_BITS-1:0] req_stamp,
  input  logic                 take,
  output logic                 hold_valid,
  output logic [AZ_W-1:0]      hold_azimuth,
  output logic [TIME_BITS-1:0] hold_stamp
);

  logic                 valid_r, valid_nxt;
  logic [AZ_W-1:0]      az_r;
  logic [TIME_BITS-1:0] stamp_r;
  logic                 load;

  assign req_ready = !valid_r || take;
  assign load      = req_valid && req_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Fold the azimuth into one turn on the way in.
  always_ff @(posedge clk) begin
    if (load) begin
      az_r    <= lss_reduce_az(req_azimuth);
      stamp_r <= req_stamp;
    end
  end

  assign hold_valid   = valid_r;
  assign hold_azimuth = az_r;
  assign hold_stamp   = stamp_r;

endmodule

// File: rtl/core/lss_tracker.sv
module lss_tracker import lss_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  proc,
  input  logic [AZ_W-1:0]       az,
  input  logic [TIME_BITS-1:0]  stamp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output lss_flags_t            flags,
  output logic [TIME_BITS-1:0]  scan_stamp,
  output logic [AZ_W-1:0]       coverage_now
);

  // Configuration
  logic                 cut_valid_r;
  logic [AZ_W-1:0]      cut_az_r;
  logic [THR_W-1:0]     thr_r;
  logic                 from_first_r;

  // Scan state
  logic                 closed_r, closed_nxt;
  logic                 has_r, has_nxt;
  logic                 start_valid_r, start_valid_nxt;
  logic [AZ_W-1:0]      start_az_r, start_az_nxt;
  logic [AZ_W-1:0]      cov_r, cov_nxt;
  logic [TIME_BITS-1:0] first_t_r, first_t_nxt;
  logic [TIME_BITS-1:0] last_t_r, last_t_nxt;
  logic [AZ_W-1:0]      last_az_r, last_az_nxt;
  logic                 held_valid_r, held_valid_nxt;
  logic [TIME_BITS-1:0] held_t_r, held_t_nxt;
  logic [AZ_W-1:0]      held_az_r, held_az_nxt;

  // State after an optional reopen, before this packet
  logic                 a_has, a_start_valid, a_held_valid;
  logic [AZ_W-1:0]      a_start, a_cov;
  logic [TIME_BITS-1:0] a_first, a_last;
  logic [AZ_W-1:0]      a_last_az;
  logic [AZ_W-1:0]      reopen_start, use_start, new_cov;
  logic [TIME_BITS-1:0] diff;
  logic                 defer;

  logic [AZ_W-1:0]      cfg_cut_az;

  assign cfg_cut_az = lss_reduce_az(cfg_wdata[AZ_W-1:0]);

  always_comb begin
    // Reopen: start from the cut angle, else the last azimuth of the old scan.
    reopen_start = cut_valid_r ? cut_az_r : last_az_r;
    a_start_valid = start_valid_r;
    a_start       = start_az_r;
    a_has         = has_r;
    a_cov         = cov_r;
    a_first       = first_t_r;
    a_last        = last_t_r;
    a_last_az     = last_az_r;
    a_held_valid  = held_valid_r;
    if (closed_r) begin
      a_start_valid = cut_valid_r || has_r;
      a_start       = reopen_start;
      a_has         = 1'b0;
      a_cov         = '0;
      if (held_valid_r) begin
        // Replay the deferred packet as the first of the new scan.
        if (!a_start_valid) begin
          a_start_valid = 1'b1;
          a_start       = held_az_r;
        end
        a_has        = 1'b1;
        a_first      = held_t_r;
        a_last       = held_t_r;
        a_last_az    = held_az_r;
        a_cov        = lss_wrap_diff(held_az_r, a_start);
        a_held_valid = 1'b0;
      end
    end

    use_start = a_start_valid ? a_start : az;
    new_cov   = lss_wrap_diff(az, use_start);

    diff  = stamp - a_first;
    defer = a_has && !diff[TIME_BITS-1] && (diff > TIME_BITS'(thr_r));

    start_valid_nxt = 1'b1;
    start_az_nxt    = use_start;
    held_valid_nxt  = a_held_valid;
    held_t_nxt      = held_t_r;
    held_az_nxt     = held_az_r;
    has_nxt         = a_has;
    first_t_nxt     = a_first;
    last_t_nxt      = a_last;
    last_az_nxt     = a_last_az;
    cov_nxt         = a_cov;
    closed_nxt      = 1'b0;
    if (defer) begin
      held_valid_nxt = 1'b1;
      held_t_nxt     = stamp;
      held_az_nxt    = az;
      closed_nxt     = 1'b1;
    end else begin
      has_nxt     = 1'b1;
      first_t_nxt = a_has ? a_first : stamp;
      last_t_nxt  = stamp;
      last_az_nxt = az;
      cov_nxt     = new_cov;
      closed_nxt  = (a_cov > HALF_TURN) && (a_cov > new_cov);
    end
  end

  assign flags.scan_done   = closed_nxt;
  assign flags.deferred    = defer;
  assign flags.starts_scan = !defer && !a_has;
  assign scan_stamp        = closed_nxt ? (from_first_r ? first_t_nxt : last_t_nxt) : '0;
  assign coverage_now      = cov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_valid_r   <= 1'b0;
      cut_az_r      <= '0;
      thr_r         <= THR_RESET;
      from_first_r  <= 1'b0;
      closed_r      <= 1'b0;
      has_r         <= 1'b0;
      start_valid_r <= 1'b0;
      start_az_r    <= '0;
      cov_r         <= '0;
      first_t_r     <= '0;
      last_t_r      <= '0;
      last_az_r     <= '0;
      held_valid_r  <= 1'b0;
    end else begin
      if (proc) begin
        closed_r      <= closed_nxt;
        has_r         <= has_nxt;
        start_valid_r <= start_valid_nxt;
        start_az_r    <= start_az_nxt;
        cov_r         <= cov_nxt;
        first_t_r     <= first_t_nxt;
        last_t_r      <= last_t_nxt;
        last_az_r     <= last_az_nxt;
        held_valid_r  <= held_valid_nxt;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          CFG_FIXED_START: begin
            cut_valid_r <= !cfg_wdata[CUT_W-1];
            cut_az_r    <= cfg_cut_az;
            // An empty scan takes a set cut angle as its start at once.
            if (!has_r && !cfg_wdata[CUT_W-1]) begin
              start_valid_r <= 1'b1;
              start_az_r    <= cfg_cut_az;
            end
          end
          CFG_DURATION_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
          CFG_STAMP_FROM_FIRST:   from_first_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      held_t_r  <= held_t_nxt;
      held_az_r <= held_az_nxt;
    end
  end

endmodule

// File: rtl/core/lss_out_reg.sv
module lss_out_reg import lss_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  output logic                 free,
  input  lss_flags_t           flags,
  input  logic [TIME_BITS-1:0] scan_stamp,
  input  logic [AZ_W-1:0]      coverage_now,
  output logic                 res_valid,
  input  logic                 res_ready,
  output lss_flags_t           res_flags,
  output logic [TIME_BITS-1:0] res_stamp,
  output logic [AZ_W-1:0]      res_coverage
);

  logic                 valid_r, valid_nxt;
  lss_flags_t           flags_r;
  logic [TIME_BITS-1:0] stamp_r;
  logic [AZ_W-1:0]      cov_r;

  assign free = !valid_r || res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= flags;
      stamp_r <= scan_stamp;
      cov_r   <= coverage_now;
    end
  end

  assign res_valid    = valid_r;
  assign res_flags    = flags_r;
  assign res_stamp    = stamp_r;
  assign res_coverage = cov_r;

endmodule

// File: rtl/core/lidar_scan_segmenter.sv
// Path: an accepted request is held in the input register, then in the result register on out_res.
// Throughput: one packet per cycle while out_res takes each result; the scan state updates per packet.
// Backpressure on out_res stalls the input register, which then drops in_pkt.ready.
// Reset (rst_n, synchronous, active low) empties both stages, clears the scan state,
// sets the fixed start angle to "follow packets", duration_threshold to 200000,
// stamp_from_first to 0.
`include "lidar_scan_segmenter_assert.svh"

module lidar_scan_segmenter import lss_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lss_pkt_if.sink               in_pkt,
  lss_res_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Input register -> tracker
  logic                 s0_valid;
  logic [AZ_W-1:0]      s0_az;
  logic [TIME_BITS-1:0] s0_stamp;

  // Tracker -> result register
  logic                 s1_free;
  logic                 proc;
  lss_flags_t           trk_flags;
  logic [TIME_BITS-1:0] trk_stamp;
  logic [AZ_W-1:0]      trk_cov;

  lss_flags_t           res_flags;

  // Hold the request here; it moves on whenever the result register is free.
  lss_in_reg #(
    .TIME_BITS (TIME_BITS)
  ) u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_pkt.valid),
    .req_ready    (in_pkt.ready),
    .req_azimuth  (in_pkt.azimuth),
    .req_stamp    (in_pkt.stamp),
    .take         (s1_free),
    .hold_valid   (s0_valid),
    .hold_azimuth (s0_az),
    .hold_stamp   (s0_stamp)
  );

  // Advance the scan state exactly when a held request moves into the result register.
  assign proc = s0_valid && s1_free;

  // Scan state, config registers and the per-packet decision:
  // reopen after a close, replay a deferred packet, test the duration,
  // then add the packet, unless it is deferred, and check for the coverage wrap.
  lss_tracker #(
    .TIME_BITS (TIME_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .proc         (proc),
    .az           (s0_az),
    .stamp        (s0_stamp),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .flags        (trk_flags),
    .scan_stamp   (trk_stamp),
    .coverage_now (trk_cov)
  );

  // Hold the result until the sink takes it; the input register fills and stalls behind it.
  lss_out_reg #(
    .TIME_BITS (TIME_BITS)
  ) u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (proc),
    .free         (s1_free),
    .flags        (trk_flags),
    .scan_stamp   (trk_stamp),
    .coverage_now (trk_cov),
    .res_valid    (out_res.valid),
    .res_ready    (out_res.ready),
    .res_flags    (res_flags),
    .res_stamp    (out_res.scan_stamp),
    .res_coverage (out_res.coverage_now)
  );

  assign out_res.scan_done   = res_flags.scan_done;
  assign out_res.deferred    = res_flags.deferred;
  assign out_res.starts_scan = res_flags.starts_scan;

  // A deferred packet always closes its scan.
  `LSS_ASSERT_NOW(a_defer_closes, out_res.valid && out_res.deferred, out_res.scan_done)
  // The first packet of a scan can neither close it nor be deferred.
  `LSS_ASSERT_NOW(a_start_not_close, out_res.valid && out_res.starts_scan,
                  !out_res.scan_done && !out_res.deferred)
  // No stamp leaks out unless the scan closed.
  `LSS_ASSERT_NOW(a_stamp_zero, out_res.valid && !out_res.scan_done, out_res.scan_stamp == '0)
  // A processed request always lands in the result register.
  `LSS_ASSERT_NEXT(a_proc_lands, proc, out_res.valid)

endmodule
